[rtl/core/iad_pkg.sv]
// package: types, constants and helpers shared by the integer to ascii digits block
package iad_pkg;

  localparam int unsigned DIGIT_SLOTS   = 20;
  localparam int unsigned HEX_DIGITS    = 16;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned BCD_W         = 4 * DIGIT_SLOTS;
  localparam int unsigned ACC_W         = BCD_W + VALUE_W;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int unsigned CNT_W         = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned STEP_W        = $clog2(CONV_STEPS);

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_HEX      = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_H     = 8'h48;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } iad_in_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             last;
    logic [CNT_W-1:0] char_count;
  } iad_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_SUFFIX
  } iad_state_e;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_DIGIT,
    SEL_SUFFIX
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      shift;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } iad_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic cnt_one;
    logic conv_last;
    logic neg;
    logic hex;
  } iad_status_t;

  // digit value to upper-case ascii
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/integer_to_ascii_digits.sv]
// top level: 64-bit integer to ascii text converter, one character per cycle
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   item in  | start high, busy low      | item_i   : mode, value
//   chars out| result_valid_o, 1 cycle   | result_o : out_char, last, char_count
//
// an item is taken at an edge with start high and busy low; busy then stays high
// until the last character is registered for output
// decimal: a shift-add-3 conversion pass (four bits a cycle), then a skip of each
// leading zero digit of the 20-digit bcd word, then the characters, with a sign
// first if negative; hex: the same without the conversion pass
// the characters leave through a register, one per cycle, and cannot be held off
// the last character shows in the same cycle in which busy falls, so the next item can be
// taken then; reset clears only control state
module integer_to_ascii_digits (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  iad_pkg::iad_in_t  item_i,
  output logic              result_valid_o,
  output iad_pkg::iad_out_t result_o
);

  // commands from the controller, status back from the datapath
  iad_pkg::iad_cmd_t    cmd;
  iad_pkg::iad_status_t status;

  iad_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  iad_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[rtl/core/iad_ctrl.sv]
// controller: sequences load, conversion, zero skip and character emission
module iad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  iad_pkg::iad_status_t status_i,
  output iad_pkg::iad_cmd_t    cmd_o,
  output logic                 busy
);

  iad_pkg::iad_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = iad_pkg::SEL_DIGIT;
    unique case (state_q)
      iad_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = iad_pkg::ST_CONV;
        end
      end
      iad_pkg::ST_CONV: begin
        // hex digits are already in place
        if (status_i.hex) begin
          state_d = iad_pkg::ST_SKIP;
        end else begin
          cmd_o.conv = 1'b1;
          if (status_i.conv_last) state_d = iad_pkg::ST_SKIP;
        end
      end
      iad_pkg::ST_SKIP: begin
        if (status_i.top_zero && !status_i.cnt_one) begin
          cmd_o.shift = 1'b1;
        end else if (status_i.neg) begin
          state_d = iad_pkg::ST_SIGN;
        end else begin
          state_d = iad_pkg::ST_DIGIT;
        end
      end
      iad_pkg::ST_SIGN: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = iad_pkg::SEL_SIGN;
        state_d    = iad_pkg::ST_DIGIT;
      end
      iad_pkg::ST_DIGIT: begin
        cmd_o.emit  = 1'b1;
        cmd_o.shift = 1'b1;
        cmd_o.last  = status_i.cnt_one && !status_i.hex;
        if (status_i.cnt_one) begin
          state_d = status_i.hex ? iad_pkg::ST_SUFFIX : iad_pkg::ST_IDLE;
        end
      end
      iad_pkg::ST_SUFFIX: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = iad_pkg::SEL_SUFFIX;
        cmd_o.last = 1'b1;
        state_d    = iad_pkg::ST_IDLE;
      end
      default: begin
        state_d = iad_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != iad_pkg::ST_IDLE);

endmodule

[rtl/core/iad_datapath.sv]
// datapath: magnitude, shift-add-3 bcd conversion, digit shifter and result register
module iad_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iad_pkg::iad_in_t     item_i,
  input  iad_pkg::iad_cmd_t    cmd_i,
  output iad_pkg::iad_status_t status_o,
  output logic                 result_valid_o,
  output iad_pkg::iad_out_t    result_o
);

  logic [iad_pkg::BCD_W-1:0]   bcd_q, bcd_d;
  logic [iad_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [iad_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [iad_pkg::STEP_W-1:0]  step_q, step_d;
  logic [iad_pkg::CNT_W-1:0]   emitted_q, emitted_d;
  logic                        neg_q, neg_d;
  logic                        hex_q, hex_d;
  iad_pkg::iad_out_t           out_q, out_d;
  logic                        valid_q;

  logic                        in_neg;
  logic                        in_hex;
  logic [iad_pkg::VALUE_W-1:0] mag;
  logic [iad_pkg::ACC_W-1:0]   dabble;
  logic [7:0]                  ch;

  assign in_neg = (item_i.mode == iad_pkg::MODE_SIGNED) && item_i.value[iad_pkg::VALUE_W-1];
  assign in_hex = (item_i.mode == iad_pkg::MODE_HEX);
  assign mag    = in_neg ? (~item_i.value + 1'b1) : item_i.value;

  // four shift-add-3 steps per cycle
  always_comb begin
    dabble = {bcd_q, bin_q};
    for (int s = 0; s < iad_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < iad_pkg::DIGIT_SLOTS; d++) begin
        if (dabble[iad_pkg::VALUE_W + 4*d +: 4] >= 4'd5) begin
          dabble[iad_pkg::VALUE_W + 4*d +: 4] = dabble[iad_pkg::VALUE_W + 4*d +: 4] + 4'd3;
        end
      end
      dabble = dabble << 1;
    end
  end

  always_comb begin
    bcd_d     = bcd_q;
    bin_d     = bin_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    neg_d     = neg_q;
    hex_d     = hex_q;
    emitted_d = emitted_q;
    if (cmd_i.load) begin
      neg_d     = in_neg;
      hex_d     = in_hex;
      step_d    = '0;
      emitted_d = '0;
      if (in_hex) begin
        bcd_d = {item_i.value, {(iad_pkg::BCD_W - iad_pkg::VALUE_W){1'b0}}};
        bin_d = '0;
        cnt_d = iad_pkg::CNT_W'(iad_pkg::HEX_DIGITS);
      end else begin
        bcd_d = '0;
        bin_d = mag;
        cnt_d = iad_pkg::CNT_W'(iad_pkg::DIGIT_SLOTS);
      end
    end else begin
      if (cmd_i.conv) begin
        {bcd_d, bin_d} = dabble;
        step_d         = step_q + 1'b1;
      end
      if (cmd_i.shift) begin
        bcd_d = bcd_q << 4;
        cnt_d = cnt_q - 1'b1;
      end
      if (cmd_i.emit) begin
        emitted_d = emitted_q + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      iad_pkg::SEL_SIGN:   ch = iad_pkg::CHAR_MINUS;
      iad_pkg::SEL_SUFFIX: ch = iad_pkg::CHAR_H;
      default:             ch = iad_pkg::digit_char(bcd_q[iad_pkg::BCD_W-1 -: 4]);
    endcase
    out_d.out_char   = ch;
    out_d.last       = cmd_i.last;
    out_d.char_count = cmd_i.last ? (emitted_q + 1'b1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q     <= bcd_d;
    bin_q     <= bin_d;
    cnt_q     <= cnt_d;
    step_q    <= step_d;
    neg_q     <= neg_d;
    hex_q     <= hex_d;
    emitted_q <= emitted_d;
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign status_o.top_zero  = (bcd_q[iad_pkg::BCD_W-1 -: 4] == 4'd0);
  assign status_o.cnt_one   = (cnt_q == iad_pkg::CNT_W'(1));
  assign status_o.conv_last = (step_q == iad_pkg::STEP_W'(iad_pkg::CONV_STEPS - 1));
  assign status_o.neg       = neg_q;
  assign status_o.hex       = hex_q;

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule

[rtl/core/iad_checker.sv]
// checker: port-level properties of the converter, bound to the top level
module iad_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input iad_pkg::iad_out_t result_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  // the end of a run is marked by a last character in the same cycle in which busy falls
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && result_o.last)
    else $error("busy fell without a last character");

  // characters only come out of a run in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("character emitted while idle");

  // count is given on the last character only, and is never zero there
  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.last == (result_o.char_count != '0)))
    else $error("char_count does not match last");

endmodule

bind integer_to_ascii_digits iad_checker u_iad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
